// File: hw/rtl/fdg_pkg.sv
package fdg_pkg;

  // Default sizes of the line buffers and the pixel word.
  localparam int MAX_COLS_DEF   = 1024;
  localparam int PIXEL_BITS_DEF = 16;

  // Fixed field widths.
  localparam int GRAD_BITS     = 24;
  localparam int ROWS_BITS     = 13;
  localparam int COLS_BITS     = 11;
  localparam int INV_BITS      = 16;
  localparam int ROW_CNT_BITS  = 12;
  localparam int MODE_BITS     = 2;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  // Image size limits and reset values.
  localparam int MIN_DIM    = 3;
  localparam int MAX_ROWS   = 4096;
  localparam int ROWS_RESET = 256;
  localparam int COLS_RESET = 256;
  localparam int INV_RESET  = 256;

  // Saturation limits of a gradient result.
  localparam logic signed [GRAD_BITS-1:0] GRAD_MAX = {1'b0, {(GRAD_BITS-1){1'b1}}};
  localparam logic signed [GRAD_BITS-1:0] GRAD_MIN = {1'b1, {(GRAD_BITS-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ROWS    = 3'd0,
    REG_COLS    = 3'd1,
    REG_MODE    = 3'd2,
    REG_INV_ROW = 3'd3,
    REG_INV_COL = 3'd4
  } cfg_reg_t;

  // Border rules. The unused code behaves as MODE_NONE.
  typedef enum logic [MODE_BITS-1:0] {
    MODE_NONE      = 2'd0,
    MODE_NEUMANN   = 2'd1,
    MODE_DIRICHLET = 2'd2
  } bnd_mode_t;

  // Kind of input item.
  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } item_op_t;

  // Position of the center pixel along one axis.
  typedef enum logic [1:0] {
    POS_FIRST,
    POS_INNER,
    POS_LAST
  } stencil_pos_t;

  // Scaling control for one gradient: force zero, or shift by 8 instead of 9.
  typedef struct packed {
    logic zero;
    logic sh8;
  } scale_ctl_t;

endpackage

// File: hw/rtl/fdg_line_buf.sv
module fdg_line_buf #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         older_wdata,
  input  logic [WIDTH-1:0]         newer_wdata,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_p1,
  output logic [WIDTH-1:0]         older_q,
  output logic [WIDTH-1:0]         newer_q,
  output logic [WIDTH-1:0]         newer_p1_q
);

  logic [WIDTH-1:0] older_mem [DEPTH];
  logic [WIDTH-1:0] newer_mem [DEPTH];

  // Row before last: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      older_mem[wr_addr] <= older_wdata;
    end
    older_q <= older_mem[rd_addr];
  end

  // Last row: one write and two registered reads per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      newer_mem[wr_addr] <= newer_wdata;
    end
    newer_q    <= newer_mem[rd_addr];
    newer_p1_q <= newer_mem[rd_addr_p1];
  end

endmodule

// File: hw/rtl/fdg_scale.sv
module fdg_scale #(
  parameter int PIXEL_BITS = 16
) (
  input  logic signed [PIXEL_BITS:0]            opnd,
  input  logic [fdg_pkg::INV_BITS-1:0]          inv_h,
  input  fdg_pkg::scale_ctl_t                   ctl,
  output logic signed [fdg_pkg::GRAD_BITS-1:0]  grad
);
  import fdg_pkg::*;

  localparam int PW = PIXEL_BITS + 1 + INV_BITS + 1;

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] shifted;

  // Signed operand times unsigned Q8.8 factor, floor shift, then saturate.
  always_comb begin
    prod    = PW'(opnd) * PW'($signed({1'b0, inv_h}));
    shifted = ctl.sh8 ? (prod >>> 8) : (prod >>> 9);
    if (ctl.zero) begin
      grad = '0;
    end else if (shifted > PW'(GRAD_MAX)) begin
      grad = GRAD_MAX;
    end else if (shifted < PW'(GRAD_MIN)) begin
      grad = GRAD_MIN;
    end else begin
      grad = shifted[GRAD_BITS-1:0];
    end
  end

endmodule

// File: hw/rtl/fdg_ctrl.sv
module fdg_ctrl #(
  parameter int MAX_COLS   = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_valid,
  input  fdg_pkg::item_op_t                   in_op,
  input  logic signed [PIXEL_BITS-1:0]        in_pixel,
  input  logic [fdg_pkg::ROWS_BITS-1:0]       rows_eff,
  input  logic [$clog2(MAX_COLS+1)-1:0]       cols_eff,
  input  logic [fdg_pkg::MODE_BITS-1:0]       mode,
  input  logic signed [PIXEL_BITS-1:0]        up_q,
  input  logic signed [PIXEL_BITS-1:0]        mid_q,
  input  logic signed [PIXEL_BITS-1:0]        right_q,
  output logic                                wr_en,
  output logic [$clog2(MAX_COLS)-1:0]         wr_addr,
  output logic [$clog2(MAX_COLS)-1:0]         rd_addr,
  output logic [$clog2(MAX_COLS)-1:0]         rd_addr_p1,
  output logic                                s1_valid,
  output logic                                s1_last,
  output logic signed [PIXEL_BITS:0]          s1_row_opnd,
  output logic signed [PIXEL_BITS:0]          s1_col_opnd,
  output fdg_pkg::scale_ctl_t                 s1_row_ctl,
  output fdg_pkg::scale_ctl_t                 s1_col_ctl
);
  import fdg_pkg::*;

  localparam int AW = $clog2(MAX_COLS);
  localparam int CW = $clog2(MAX_COLS + 1);

  logic [AW-1:0]           col_count_r, col_count_nxt;
  logic [AW-1:0]           drain_count_r, drain_count_nxt;
  logic [ROW_CNT_BITS-1:0] row_count_r, row_count_nxt;
  logic                    frame_full_r, frame_full_nxt;
  logic signed [PIXEL_BITS-1:0] left_r;

  logic                    acc, pix_ok, drn_ok, has_res;
  logic [AW-1:0]           c_sel;
  logic [CW:0]             c_p1;
  logic                    c_last, row_last;
  stencil_pos_t            row_pos, col_pos;
  logic signed [PIXEL_BITS-1:0] row_next;
  logic signed [PIXEL_BITS:0]   row_opnd, col_opnd;
  scale_ctl_t              row_ctl, col_ctl;

  logic                         s1_valid_r, s1_last_r;
  logic signed [PIXEL_BITS:0]   s1_row_opnd_r, s1_col_opnd_r;
  scale_ctl_t                   s1_row_ctl_r, s1_col_ctl_r;

  // Operand and scaling for one axis from its three stencil taps.
  function automatic void form_opnd(
    input  stencil_pos_t                 pos,
    input  logic signed [PIXEL_BITS-1:0] prev_v,
    input  logic signed [PIXEL_BITS-1:0] cur_v,
    input  logic signed [PIXEL_BITS-1:0] nxt_v,
    input  logic [MODE_BITS-1:0]         md,
    output logic signed [PIXEL_BITS:0]   opnd,
    output scale_ctl_t                   ctl
  );
    logic signed [PIXEL_BITS:0] p;
    logic signed [PIXEL_BITS:0] c;
    logic signed [PIXEL_BITS:0] n;
    p        = {prev_v[PIXEL_BITS-1], prev_v};
    c        = {cur_v[PIXEL_BITS-1], cur_v};
    n        = {nxt_v[PIXEL_BITS-1], nxt_v};
    opnd     = '0;
    ctl.zero = 1'b1;
    ctl.sh8  = 1'b0;
    if (pos == POS_INNER) begin
      opnd     = n - p;
      ctl.zero = 1'b0;
    end else if (md == MODE_NEUMANN) begin
      opnd     = (pos == POS_FIRST) ? (n - c) : (c - p);
      ctl.zero = 1'b0;
    end else if (md == MODE_DIRICHLET) begin
      opnd     = (pos == POS_FIRST) ? n : -p;
      ctl.zero = 1'b0;
      ctl.sh8  = 1'b1;
    end
  endfunction

  // Item qualification: pixels count until the frame is full, drains after.
  assign acc     = in_valid & adv;
  assign pix_ok  = acc & (in_op == OP_PIXEL) & ~frame_full_r;
  assign drn_ok  = acc & (in_op == OP_DRAIN) & frame_full_r;
  assign has_res = (pix_ok & (row_count_r != '0)) | drn_ok;

  // Current column of whichever counter is live.
  assign c_sel    = frame_full_r ? drain_count_r : col_count_r;
  assign c_p1     = (CW+1)'(c_sel) + (CW+1)'(1);
  assign c_last   = c_p1 >= (CW+1)'(cols_eff);
  assign row_last = (ROWS_BITS'(row_count_r) + ROWS_BITS'(1)) >= rows_eff;

  // Raster counters and frame state.
  always_comb begin
    col_count_nxt   = col_count_r;
    drain_count_nxt = drain_count_r;
    row_count_nxt   = row_count_r;
    frame_full_nxt  = frame_full_r;
    if (pix_ok) begin
      if (c_last) begin
        col_count_nxt = '0;
        if (row_last) begin
          row_count_nxt  = '0;
          frame_full_nxt = 1'b1;
        end else begin
          row_count_nxt = row_count_r + 1'b1;
        end
      end else begin
        col_count_nxt = c_p1[AW-1:0];
      end
    end
    if (drn_ok) begin
      if (c_last) begin
        drain_count_nxt = '0;
        row_count_nxt   = '0;
        col_count_nxt   = '0;
        frame_full_nxt  = 1'b0;
      end else begin
        drain_count_nxt = c_p1[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_count_r   <= '0;
      drain_count_r <= '0;
      row_count_r   <= '0;
      frame_full_r  <= 1'b0;
    end else begin
      col_count_r   <= col_count_nxt;
      drain_count_r <= drain_count_nxt;
      row_count_r   <= row_count_nxt;
      frame_full_r  <= frame_full_nxt;
    end
  end

  // Line buffer reads are set up for the next item, so data waits registered.
  assign rd_addr    = frame_full_nxt ? drain_count_nxt : col_count_nxt;
  assign rd_addr_p1 = rd_addr + 1'b1;
  assign wr_en      = pix_ok;
  assign wr_addr    = col_count_r;

  // The left tap is the center tap of the previous item in the same row.
  always_ff @(posedge clk) begin
    if (pix_ok | drn_ok) begin
      left_r <= mid_q;
    end
  end

  // Stencil positions and operands for both axes.
  always_comb begin
    if (c_sel == '0) begin
      col_pos = POS_FIRST;
    end else if (c_last) begin
      col_pos = POS_LAST;
    end else begin
      col_pos = POS_INNER;
    end
    if (frame_full_r) begin
      row_pos  = POS_LAST;
      row_next = '0;
    end else begin
      row_pos  = (row_count_r == ROW_CNT_BITS'(1)) ? POS_FIRST : POS_INNER;
      row_next = in_pixel;
    end
    form_opnd(row_pos, up_q, mid_q, row_next, mode, row_opnd, row_ctl);
    form_opnd(col_pos, left_r, mid_q, right_q, mode, col_opnd, col_ctl);
  end

  // Operand stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= has_res;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_last_r     <= drn_ok & c_last;
      s1_row_opnd_r <= row_opnd;
      s1_col_opnd_r <= col_opnd;
      s1_row_ctl_r  <= row_ctl;
      s1_col_ctl_r  <= col_ctl;
    end
  end

  assign s1_valid    = s1_valid_r;
  assign s1_last     = s1_last_r;
  assign s1_row_opnd = s1_row_opnd_r;
  assign s1_col_opnd = s1_col_opnd_r;
  assign s1_row_ctl  = s1_row_ctl_r;
  assign s1_col_ctl  = s1_col_ctl_r;

`ifndef SYNTHESIS
  // A full frame waits for drains with the raster counters parked at zero.
  a_full_parked: assert property (@(posedge clk) disable iff (!rst_n)
    frame_full_r |-> (col_count_r == '0 && row_count_r == '0))
    else $error("raster counters moved while frame full");

  // Draining only happens on a full frame.
  a_drain_in_full: assert property (@(posedge clk) disable iff (!rst_n)
    (drain_count_r != '0) |-> frame_full_r)
    else $error("drain counter active outside a full frame");
`endif

endmodule

// File: hw/rtl/finite_difference_gradient_2d.sv
// Central-difference gradient of a raster image stream.
// Input channel (in_*): one item per pixel in raster order, in_tuser selects
// a pixel (0) or a drain tick (1). Each pixel from the second row on yields
// the row and column gradient of the pixel one row above it. After the last
// pixel of the image, one drain tick per column yields the last row; the
// final result carries out_tlast. Drains before the image is complete and
// pixels after it is complete are taken and dropped.
// Result channel (out_*): grad_row and grad_col packed in out_tdata.
// Configuration channel (cfg_*): always ready; write only while idle.
// Throughput: one item per cycle while the output side does not stall. A result
// is registered first in the operand register, then multiplied and saturated
// into the output register. Line buffer reads for the next item are issued
// in the cycle that the current one is taken, so no bubble is needed.
// When out_tready is low, the output and operand registers fill and
// in_tready falls; in_tready stays high whenever the output register is
// empty. Reset clears the counters and pipeline and loads the default
// configuration; line buffer contents are undefined until written.
module finite_difference_gradient_2d #(
  parameter int MAX_COLS   = fdg_pkg::MAX_COLS_DEF,
  parameter int PIXEL_BITS = fdg_pkg::PIXEL_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Input item.
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]        in_tdata,  // pixel
  input  logic                                   in_tuser,  // op
  // Result item.
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [2*fdg_pkg::GRAD_BITS-1:0]        out_tdata, // grad_col high, grad_row low
  output logic                                   out_tlast,
  // Configuration writes.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [fdg_pkg::CFG_IDX_BITS-1:0]       cfg_index,
  input  logic [fdg_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
  import fdg_pkg::*;

  localparam int AW = $clog2(MAX_COLS);
  localparam int CW = $clog2(MAX_COLS + 1);

  logic [ROWS_BITS-1:0] rows_r;
  logic [CW-1:0]        cols_r;
  logic [MODE_BITS-1:0] mode_r;
  logic [INV_BITS-1:0]  inv_row_r, inv_col_r;

  logic out_valid_r, out_last_r;
  logic signed [GRAD_BITS-1:0] out_row_r, out_col_r;
  logic out_ready, s1_ready;

  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr, rd_addr_p1;
  logic signed [PIXEL_BITS-1:0] in_pixel, up_q, mid_q, right_q;

  logic                       s1_valid, s1_last;
  logic signed [PIXEL_BITS:0] s1_row_opnd, s1_col_opnd;
  scale_ctl_t                 s1_row_ctl, s1_col_ctl;
  logic signed [GRAD_BITS-1:0] grad_row, grad_col;

  // Clamp a row count to the supported range.
  function automatic logic [ROWS_BITS-1:0] clamp_rows(input logic [ROWS_BITS-1:0] v);
    logic [ROWS_BITS-1:0] r;
    r = v;
    if (v < ROWS_BITS'(MIN_DIM)) begin
      r = ROWS_BITS'(MIN_DIM);
    end else if (v > ROWS_BITS'(MAX_ROWS)) begin
      r = ROWS_BITS'(MAX_ROWS);
    end
    return r;
  endfunction

  // Clamp a column count to the minimum size and the line buffer depth.
  function automatic logic [CW-1:0] clamp_cols(input logic [COLS_BITS-1:0] v);
    logic [CW-1:0] r;
    r = CW'(v);
    if (v < COLS_BITS'(MIN_DIM)) begin
      r = CW'(MIN_DIM);
    end else if (32'(v) > 32'(MAX_COLS)) begin
      r = CW'(MAX_COLS);
    end
    return r;
  endfunction

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= ROWS_BITS'(ROWS_RESET);
      cols_r    <= clamp_cols(COLS_BITS'(COLS_RESET));
      mode_r    <= MODE_NEUMANN;
      inv_row_r <= INV_BITS'(INV_RESET);
      inv_col_r <= INV_BITS'(INV_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROWS:    rows_r    <= clamp_rows(cfg_data[ROWS_BITS-1:0]);
        REG_COLS:    cols_r    <= clamp_cols(cfg_data[COLS_BITS-1:0]);
        REG_MODE:    mode_r    <= cfg_data[MODE_BITS-1:0];
        REG_INV_ROW: inv_row_r <= cfg_data[INV_BITS-1:0];
        REG_INV_COL: inv_col_r <= cfg_data[INV_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control: each stage loads when the one after it can move.
  assign out_ready = ~out_valid_r | out_tready;
  assign s1_ready  = ~s1_valid | out_ready;
  assign in_tready = s1_ready;
  assign in_pixel  = $signed(in_tdata[PIXEL_BITS-1:0]);

  fdg_line_buf #(
    .DEPTH (MAX_COLS),
    .WIDTH (PIXEL_BITS)
  ) u_line_buf (
    .clk         (clk),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .older_wdata (mid_q),
    .newer_wdata (in_pixel),
    .rd_addr     (rd_addr),
    .rd_addr_p1  (rd_addr_p1),
    .older_q     (up_q),
    .newer_q     (mid_q),
    .newer_p1_q  (right_q)
  );

  fdg_ctrl #(
    .MAX_COLS   (MAX_COLS),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (s1_ready),
    .in_valid    (in_tvalid),
    .in_op       (item_op_t'(in_tuser)),
    .in_pixel    (in_pixel),
    .rows_eff    (rows_r),
    .cols_eff    (cols_r),
    .mode        (mode_r),
    .up_q        (up_q),
    .mid_q       (mid_q),
    .right_q     (right_q),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr),
    .rd_addr_p1  (rd_addr_p1),
    .s1_valid    (s1_valid),
    .s1_last     (s1_last),
    .s1_row_opnd (s1_row_opnd),
    .s1_col_opnd (s1_col_opnd),
    .s1_row_ctl  (s1_row_ctl),
    .s1_col_ctl  (s1_col_ctl)
  );

  fdg_scale #(.PIXEL_BITS(PIXEL_BITS)) u_scale_row (
    .opnd  (s1_row_opnd),
    .inv_h (inv_row_r),
    .ctl   (s1_row_ctl),
    .grad  (grad_row)
  );

  fdg_scale #(.PIXEL_BITS(PIXEL_BITS)) u_scale_col (
    .opnd  (s1_col_opnd),
    .inv_h (inv_col_r),
    .ctl   (s1_col_ctl),
    .grad  (grad_col)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && s1_valid) begin
      out_row_r  <= grad_row;
      out_col_r  <= grad_col;
      out_last_r <= s1_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_col_r, out_row_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // An empty output register never blocks the input side.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  // A new result comes only from a filled operand stage.
  a_rose_from_s1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_valid))
    else $error("result appeared without an operand stage item");
`endif

endmodule

// File: sim/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fdg_pkg::*;

  localparam int NUM_COLS = MAX_COLS_DEF;
  localparam int PX_W = PIXEL_BITS_DEF;
  localparam int DATA_W = ((PX_W + 7) / 8) * 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  // Results pass through the operand and output registers; leave margin before a register write.
  localparam int SETTLE_CYCLES = 8;
  localparam int PRINT_MAX = 30;
  localparam int ITEMS_PER_PHASE = 200;
  // Mode code outside the defined set; the block treats it as no border rule.
  localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic signed [GRAD_BITS-1:0] grad_row;
    logic signed [GRAD_BITS-1:0] grad_col;
    logic                        last;
  } gradient_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_tvalid = 1'b0;
  logic                       in_tready;
  logic [DATA_W-1:0]          in_tdata = '0;  // pixel
  logic                       in_tuser = 1'b0; // op
  logic                       out_tvalid;
  logic                       out_tready = 1'b0;
  logic [2*GRAD_BITS-1:0]     out_tdata;      // grad_col high, grad_row low
  logic                       out_tlast;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_BITS-1:0]    cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]   cfg_data = '0;

  // Shadow configuration, starting from the reset values.
  logic [ROWS_BITS-1:0]       rows_r = ROWS_BITS'(ROWS_RESET);
  logic [COLS_BITS-1:0]       cols_r = COLS_BITS'(COLS_RESET);
  logic [MODE_BITS-1:0]       mode_r = MODE_NEUMANN;
  logic [INV_BITS-1:0]        inv_row_r = INV_BITS'(INV_RESET);
  logic [INV_BITS-1:0]        inv_col_r = INV_BITS'(INV_RESET);

  // Shadow line buffers and raster position.
  logic signed [PX_W-1:0]     older_px [NUM_COLS];
  logic signed [PX_W-1:0]     newer_px [NUM_COLS];
  int unsigned                row_cnt = 0;
  int unsigned                col_cnt = 0;
  int unsigned                drain_cnt = 0;
  bit                         img_full = 1'b0;

  gradient_t                  pending_gradients[$];
  int                         mismatch_count = 0;
  int unsigned                cycle_count = 0;
  int                         items_sent = 0;
  int                         send_idle_pct = 0;
  int                         stall_pct = 0;

  finite_difference_gradient_2d DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_MAX) $display("mismatch: %s", msg);
  endtask

  // Saturate to the signed result width.
  function automatic logic signed [GRAD_BITS-1:0] sat_grad(longint v);
    if (v > longint'(GRAD_MAX)) return GRAD_MAX;
    if (v < longint'(GRAD_MIN)) return GRAD_MIN;
    return v[GRAD_BITS-1:0];
  endfunction

  // One-axis gradient of the center sample, following the border rule.
  function automatic logic signed [GRAD_BITS-1:0] axis_gradient(stencil_pos_t pos,
      longint prv, longint cur, longint nxt, logic [INV_BITS-1:0] inv);
    longint f;
    f = longint'(inv);
    if (pos == POS_INNER) return sat_grad(((nxt - prv) * f) >>> 9);
    if (mode_r == MODE_NEUMANN)
      return sat_grad((((pos == POS_FIRST) ? (nxt - cur) : (cur - prv)) * f) >>> 9);
    if (mode_r == MODE_DIRICHLET)
      return sat_grad((((pos == POS_FIRST) ? nxt : -prv) * f) >>> 8);
    return '0;
  endfunction

  function automatic int unsigned image_rows();
    if (32'(rows_r) < MIN_DIM) return MIN_DIM;
    if (32'(rows_r) > MAX_ROWS) return MAX_ROWS;
    return 32'(rows_r);
  endfunction

  function automatic int unsigned image_cols();
    if (32'(cols_r) < MIN_DIM) return MIN_DIM;
    if (32'(cols_r) > NUM_COLS) return NUM_COLS;
    return 32'(cols_r);
  endfunction

  // Advance the shadow raster by one accepted item and queue any gradient it yields.
  function automatic void predict_gradient(item_op_t op, logic [PX_W-1:0] px);
    int unsigned nc, nr, c;
    longint up, mid, lft, rgt, pxv;
    stencil_pos_t cpos;
    gradient_t res;
    bit emit;
    nc = image_cols();
    nr = image_rows();
    emit = 1'b0;
    res.last = 1'b0;
    if (op == OP_PIXEL) begin
      if (img_full) return;
      c = col_cnt;
      pxv = longint'($signed(px));
      if (row_cnt >= 1) begin
        up = longint'(older_px[c]);
        mid = longint'(newer_px[c]);
        lft = (c > 0) ? longint'(older_px[c-1]) : longint'(0);
        rgt = (c + 1 < NUM_COLS) ? longint'(newer_px[c+1]) : longint'(0);
        cpos = (c == 0) ? POS_FIRST : ((c + 1 >= nc) ? POS_LAST : POS_INNER);
        res.grad_row = axis_gradient((row_cnt == 1) ? POS_FIRST : POS_INNER,
                                     up, mid, pxv, inv_row_r);
        res.grad_col = axis_gradient(cpos, lft, mid, rgt, inv_col_r);
        emit = 1'b1;
      end
      older_px[c] = newer_px[c];
      newer_px[c] = px;
      if (c + 1 >= nc) begin
        col_cnt = 0;
        if (row_cnt + 1 >= nr) begin
          row_cnt = 0;
          img_full = 1'b1;
        end else begin
          row_cnt++;
        end
      end else begin
        col_cnt = c + 1;
      end
    end else begin
      if (!img_full) return;
      c = drain_cnt;
      up = longint'(older_px[c]);
      mid = longint'(newer_px[c]);
      lft = (c > 0) ? longint'(newer_px[c-1]) : longint'(0);
      rgt = (c + 1 < NUM_COLS) ? longint'(newer_px[c+1]) : longint'(0);
      cpos = (c == 0) ? POS_FIRST : ((c + 1 >= nc) ? POS_LAST : POS_INNER);
      res.grad_row = axis_gradient(POS_LAST, up, mid, longint'(0), inv_row_r);
      res.grad_col = axis_gradient(cpos, lft, mid, rgt, inv_col_r);
      emit = 1'b1;
      if (c + 1 >= nc) begin
        res.last = 1'b1;
        drain_cnt = 0;
        row_cnt = 0;
        col_cnt = 0;
        img_full = 1'b0;
      end else begin
        drain_cnt = c + 1;
      end
    end
    if (emit) pending_gradients.push_back(res);
  endfunction

  // Result checker: handshake values are stable at the falling edge.
  always @(negedge clk) begin
    gradient_t want;
    logic signed [GRAD_BITS-1:0] got_row, got_col;
    if (rst_n && out_tvalid && out_tready) begin
      got_row = out_tdata[GRAD_BITS-1:0];
      got_col = out_tdata[2*GRAD_BITS-1:GRAD_BITS];
      if (pending_gradients.size() == 0) begin
        report_mismatch($sformatf("unexpected result row %0d col %0d last %0b",
                                  got_row, got_col, out_tlast));
      end else begin
        want = pending_gradients.pop_front();
        if (got_row !== want.grad_row)
          report_mismatch($sformatf("grad_row got %0d want %0d", got_row, want.grad_row));
        if (got_col !== want.grad_col)
          report_mismatch($sformatf("grad_col got %0d want %0d", got_col, want.grad_col));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last got %0b want %0b", out_tlast, want.last));
      end
    end
  end

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
  endtask

  // Send one item; returns in the time step of the edge that accepts it.
  task automatic send_item(item_op_t op, logic [PX_W-1:0] px);
    bit ok;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    in_tuser <= op;
    do begin
      @(negedge clk);
      ok = in_tready;
      @(posedge clk);
    end while (!ok);
    predict_gradient(op, px);
  endtask

  // Hold the sender until every queued gradient has come out.
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_gradients.size() != 0);
  endtask

  task automatic go_idle();
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
    bit ok;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk);
      ok = cfg_ready;
      @(posedge clk);
    end while (!ok);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ROWS:    rows_r = val[ROWS_BITS-1:0];
      REG_COLS:    cols_r = val[COLS_BITS-1:0];
      REG_MODE:    mode_r = val[MODE_BITS-1:0];
      REG_INV_ROW: inv_row_r = val;
      REG_INV_COL: inv_col_r = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [PX_W-1:0] pick_pixel();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2, 3:    return PX_W'($urandom_range(64) - 32);
      default: return PX_W'($urandom);
    endcase
  endfunction

  function automatic logic [INV_BITS-1:0] pick_inv();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'd256;
      default: return INV_BITS'($urandom);
    endcase
  endfunction

  // One whole image plus its drain, with optional ignored items mixed in.
  task automatic send_frame(int noise_pct, int pause_pm);
    while (!img_full) begin
      if ($urandom_range(99) < noise_pct) send_item(OP_DRAIN, PX_W'($urandom));
      send_item(OP_PIXEL, pick_pixel());
      items_sent++;
      if ($urandom_range(999) < pause_pm) wait_results_done();
    end
    while (img_full) begin
      if ($urandom_range(99) < noise_pct) send_item(OP_PIXEL, pick_pixel());
      send_item(OP_DRAIN, PX_W'($urandom));
      items_sent++;
    end
  endtask

  // Smallest image with extreme samples; early drain and late pixel are dropped.
  task automatic test_directed();
    logic [PX_W-1:0] corner_px [9] = '{16'h8000, 16'h7FFF, 16'h0000,
                                       16'h7FFF, 16'h8000, 16'hFFFF,
                                       16'h8000, 16'h7FFF, 16'h0001};
    set_idling(0, 0);
    // Mode and spacing stay at their reset values for the first image.
    cfg_write(REG_ROWS, 16'd3);
    cfg_write(REG_COLS, 16'd3);
    send_item(OP_DRAIN, 16'h7FFF);
    foreach (corner_px[i]) send_item(OP_PIXEL, corner_px[i]);
    send_item(OP_PIXEL, 16'h1234);
    repeat (3) send_item(OP_DRAIN, 16'h0000);
    go_idle();
    cfg_write(REG_MODE, CFG_DATA_BITS'(MODE_DIRICHLET));
    cfg_write(REG_INV_ROW, 16'hFFFF);
    cfg_write(REG_INV_COL, 16'hFFFF);
    foreach (corner_px[i]) send_item(OP_PIXEL, corner_px[8-i]);
    repeat (3) send_item(OP_DRAIN, 16'hFFFF);
  endtask

  // Every border rule against extreme and ordinary spacings.
  task automatic test_boundary_modes();
    logic [MODE_BITS-1:0] modes [4] = '{MODE_NONE, MODE_NEUMANN, MODE_DIRICHLET,
                                        MODE_UNUSED};
    logic [INV_BITS-1:0] invs [4] = '{16'd1, 16'd0, 16'hFFFF, 16'd256};
    set_idling(14, 14);
    foreach (modes[m]) begin
      foreach (invs[k]) begin
        go_idle();
        cfg_write(REG_MODE, CFG_DATA_BITS'(modes[m]));
        cfg_write(REG_INV_ROW, invs[k]);
        cfg_write(REG_INV_COL, invs[3-k]);
        cfg_write(REG_ROWS, CFG_DATA_BITS'(3 + k));
        cfg_write(REG_COLS, CFG_DATA_BITS'(3 + 2 * m + k));
        send_frame(5, 0);
      end
    end
  endtask

  // Sender stops mid-image until the pipeline is empty, then resumes.
  task automatic test_pause_until_drained();
    set_idling(14, 14);
    go_idle();
    cfg_write(REG_MODE, CFG_DATA_BITS'(MODE_NEUMANN));
    cfg_write(REG_ROWS, 16'd5);
    cfg_write(REG_COLS, 16'd6);
    send_frame(0, 150);
  endtask

  // Size registers with dropped upper bits or values under the minimum read as clamped.
  task automatic test_size_extremes();
    set_idling(0, 0);
    go_idle();
    cfg_write(REG_ROWS, 16'hE002);
    cfg_write(REG_COLS, 16'h0001);
    cfg_write(REG_MODE, CFG_DATA_BITS'(MODE_DIRICHLET));
    send_frame(0, 0);
    go_idle();
    cfg_write(REG_ROWS, 16'h0000);
    cfg_write(REG_COLS, 16'hF800);
    cfg_write(REG_MODE, CFG_DATA_BITS'(MODE_NEUMANN));
    send_frame(0, 0);
  endtask

  task automatic random_config();
    logic [CFG_DATA_BITS-ROWS_BITS-1:0] rows_hi;
    logic [CFG_DATA_BITS-COLS_BITS-1:0] cols_hi;
    int unsigned nr, nc;
    rows_hi = (CFG_DATA_BITS-ROWS_BITS)'($urandom);
    cols_hi = (CFG_DATA_BITS-COLS_BITS)'($urandom);
    nr = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
    case ($urandom_range(19))
      0:       nc = $urandom_range(2);
      1, 2:    nc = $urandom_range(25, 64);
      default: nc = $urandom_range(3, 24);
    endcase
    go_idle();
    cfg_write(REG_ROWS, {rows_hi, ROWS_BITS'(nr)});
    cfg_write(REG_COLS, {cols_hi, COLS_BITS'(nc)});
    cfg_write(REG_MODE, CFG_DATA_BITS'($urandom));
    cfg_write(REG_INV_ROW, pick_inv());
    cfg_write(REG_INV_COL, pick_inv());
  endtask

  // Random images under each idling pattern.
  task automatic test_random_frames();
    int send_pcts [4] = '{0, 67, 0, 14};
    int recv_pcts [4] = '{0, 0, 67, 14};
    int start;
    foreach (send_pcts[p]) begin
      set_idling(send_pcts[p], recv_pcts[p]);
      start = items_sent;
      random_config();
      while (items_sent - start < ITEMS_PER_PHASE) begin
        if ($urandom_range(2) == 0) random_config();
        send_frame(3, 3);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_boundary_modes();
    test_pause_until_drained();
    test_size_extremes();
    test_random_frames();
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
